// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // bit positions in a transaction mask
  localparam int RES_BYTE0  = 0;
  localparam int RES_BYTE1  = 1;
  localparam int RES_BYTE2  = 2;
  localparam int RES_STATUS = 3;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_LENGTH  = 2'd1,
    STAT_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  // one group of results for the back end
  typedef struct packed {
    logic [3:0]      mask;
    logic [2:0][7:0] data_bytes;
    status_t         status;
  } job_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t r;
    r.valid = 1'b1;
    r.value = 6'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      r.value = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      r.value = 6'(ch - 8'h47);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      r.value = 6'(ch + 8'h04);
    end else if (ch == 8'h2B) begin
      r.value = 6'd62;
    end else if (ch == 8'h2F) begin
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/base64_stream_decoder_unit.sv =====
// Channel  Direction  tdata                                  tuser  tlast
// s_*      in         [7:0] character                        -      end_of_string
// m_*      out        [7:0] data_byte, [9:8] status          kind   last
//
// One character is taken per cycle while the job queue has room.
// A group of four yields up to three bytes; end of string adds a status result.
// Results leave at one per cycle while m_tready is high, from a registered output stage.
// Synchronous reset clears group state, queue and output valid.
// A stall on m_tready fills the queue, then drops s_tready.
`include "assert_macros.svh"

module base64_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] character
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] status, [15:10] zero
  output logic        m_tuser,   // kind
  output logic        m_tlast
);

  b64d_pkg::job_t push_job;
  b64d_pkg::job_t head;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .queue_full (full),
    .job_push   (push),
    .job        (push_job)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `ASSERT_IMPLIES(a_ready_tracks_queue, full, !s_tready, "ready high with full queue")

endmodule

// ===== sv/b64d_front.sv =====
module b64d_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] character
  input  logic            s_tlast,
  input  logic            queue_full,
  output logic            job_push,
  output b64d_pkg::job_t  job
);

  logic [1:0]        group_position;
  logic [17:0]       held_sextets;
  logic              third_is_pad;
  logic              bad_char_seen;

  b64d_pkg::sextet_t lookup;
  logic              accept;
  logic              is_pad;
  logic              char_ok;
  logic [5:0]        val;
  logic              bad_now;
  logic              group_done;
  logic              emit;
  logic [5:0]        v1, v2, v3;

  assign s_tready   = !rst && !queue_full;
  assign accept     = s_tvalid && s_tready;
  assign lookup     = b64d_pkg::sextet_of(s_tdata);
  assign is_pad     = (s_tdata == b64d_pkg::PAD_CHAR);
  assign char_ok    = lookup.valid || (is_pad && group_position[1]);
  assign val        = lookup.valid ? lookup.value : 6'd0;
  assign bad_now    = bad_char_seen || !char_ok;
  assign group_done = (group_position == 2'd3);
  assign emit       = group_done && !bad_now;
  assign v1         = held_sextets[17:12];
  assign v2         = held_sextets[11:6];
  assign v3         = held_sextets[5:0];

  always_comb begin
    job = '0;
    job.data_bytes[0] = {v1, v2[5:4]};
    job.data_bytes[1] = {v2[3:0], v3[5:2]};
    job.data_bytes[2] = {v3[1:0], val};
    job.mask[b64d_pkg::RES_BYTE0]  = emit;
    job.mask[b64d_pkg::RES_BYTE1]  = emit && !third_is_pad;
    job.mask[b64d_pkg::RES_BYTE2]  = emit && !is_pad;
    job.mask[b64d_pkg::RES_STATUS] = s_tlast;
    priority if (!group_done) begin
      job.status = b64d_pkg::STAT_LENGTH;
    end else if (bad_now) begin
      job.status = b64d_pkg::STAT_INVALID;
    end else begin
      job.status = b64d_pkg::STAT_OK;
    end
  end

  assign job_push = accept && (emit || s_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
      held_sextets   <= '0;
      third_is_pad   <= 1'b0;
      bad_char_seen  <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        group_position <= 2'd0;
        held_sextets   <= '0;
        third_is_pad   <= 1'b0;
        bad_char_seen  <= 1'b0;
      end else begin
        group_position <= group_position + 2'd1;
        bad_char_seen  <= bad_now;
        unique case (group_position)
          2'd0: begin
            held_sextets <= {val, 12'd0};
            third_is_pad <= 1'b0;
          end
          2'd1: held_sextets[11:6] <= val;
          2'd2: begin
            held_sextets[5:0] <= val;
            third_is_pad      <= is_pad;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sv/b64d_queue.sv =====
`include "assert_macros.svh"

module b64d_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64d_pkg::job_t push_job,
  input  logic           pop,
  output b64d_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  b64d_pkg::job_t                  slots [b64d_pkg::QUEUE_DEPTH];
  logic [b64d_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [b64d_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [b64d_pkg::QUEUE_AW:0]     count;

  assign full  = (count == (b64d_pkg::QUEUE_AW + 1)'(b64d_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, push, !full, "push into full queue")
  `ASSERT_IMPLIES(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

// ===== sv/b64d_back.sv =====
`include "assert_macros.svh"

module b64d_back (
  input  logic            clk,
  input  logic            rst,
  input  b64d_pkg::job_t  head,
  input  logic            empty,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,   // [7:0] data_byte, [9:8] status, [15:10] zero
  output logic            m_tuser,   // kind
  output logic            m_tlast
);

  b64d_pkg::job_t cur;
  logic [3:0]     pend;
  logic [3:0]     sel;
  logic [3:0]     pend_rest;
  logic           out_free;
  logic           advance;
  logic [7:0]     res_byte;
  logic [1:0]     res_status;
  logic           res_kind;

  assign sel       = pend & (~pend + 4'd1);
  assign pend_rest = pend & ~sel;
  assign out_free  = !m_tvalid || m_tready;
  assign advance   = (pend != 4'd0) && out_free;
  assign pop       = !empty && ((pend == 4'd0) || (advance && (pend_rest == 4'd0)));

  always_comb begin
    res_byte   = 8'd0;
    res_status = b64d_pkg::STAT_OK;
    res_kind   = b64d_pkg::KIND_DATA;
    priority if (pend[b64d_pkg::RES_BYTE0]) begin
      res_byte = cur.data_bytes[0];
    end else if (pend[b64d_pkg::RES_BYTE1]) begin
      res_byte = cur.data_bytes[1];
    end else if (pend[b64d_pkg::RES_BYTE2]) begin
      res_byte = cur.data_bytes[2];
    end else begin
      res_status = cur.status;
      res_kind   = b64d_pkg::KIND_STATUS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend     <= 4'd0;
    end else begin
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        pend <= head.mask;
      end else if (advance) begin
        pend <= pend_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance) begin
      m_tdata <= {6'd0, res_status, res_byte};
      m_tuser <= res_kind;
      m_tlast <= (pend_rest == 4'd0);
    end
  end

  `ASSERT_IMPLIES(a_status_is_last, m_tvalid && m_tuser, m_tlast, "status not last")
  `ASSERT_IMPLIES(a_data_zero_status, m_tvalid && !m_tuser, m_tdata[15:8] == 8'd0,
                  "data result with status bits")

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_CHARS   = 270;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    logic                kind;
    logic [7:0]          data;
    b64d_pkg::status_t   status;
    logic                last;
  } decoded_t;

  // 6-bit value of an alphabet character, -1 outside the alphabet
  function automatic int char_to_sextet(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - 8'h41;
    if (c >= "a" && c <= "z") return int'(c) - 8'h61 + 26;
    if (c >= "0" && c <= "9") return int'(c) - 8'h30 + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] sextet_to_char(int v);
    if (v < 26) return 8'(8'h41 + v);
    if (v < 52) return 8'(8'h61 + v - 26);
    if (v < 62) return 8'(8'h30 + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  class b64_decode_tracker;
    logic [1:0]  group_pos;
    logic [17:0] held;
    bit          third_pad;
    bit          bad_seen;
    decoded_t    awaited[$];
    int          mismatches;
    int          n_chars;
    int          n_bytes;
    int          n_status[3];

    function new();
      clear_group();
    endfunction

    function void clear_group();
      group_pos = '0;
      held      = '0;
      third_pad = 1'b0;
      bad_seen  = 1'b0;
    endfunction

    function void push(logic kind, logic [7:0] data, b64d_pkg::status_t st);
      decoded_t r;
      r.kind   = kind;
      r.data   = data;
      r.status = st;
      r.last   = 1'b0;
      awaited.push_back(r);
    endfunction

    function void note_char(logic [7:0] ch, logic eos);
      int                v;
      int                first_new;
      bit                pad;
      logic [5:0]        val;
      logic [5:0]        s1;
      logic [5:0]        s2;
      logic [5:0]        s3;
      b64d_pkg::status_t st;
      first_new = awaited.size();
      n_chars++;
      pad = (ch == b64d_pkg::PAD_CHAR);
      v = char_to_sextet(ch);
      if (pad && group_pos >= 2'd2) v = 0;
      if (v < 0) begin
        bad_seen = 1'b1;
        val = '0;
      end else begin
        val = v[5:0];
      end
      case (group_pos)
        2'd0: begin
          held = {val, 12'd0};
          third_pad = 1'b0;
        end
        2'd1: held[11:6] = val;
        2'd2: begin
          held[5:0] = val;
          third_pad = pad;
        end
        default: begin
          if (!bad_seen) begin
            s1 = held[17:12];
            s2 = held[11:6];
            s3 = held[5:0];
            push(b64d_pkg::KIND_DATA, {s1, s2[5:4]}, b64d_pkg::STAT_OK);
            if (!third_pad)
              push(b64d_pkg::KIND_DATA, {s2[3:0], s3[5:2]}, b64d_pkg::STAT_OK);
            if (!pad) push(b64d_pkg::KIND_DATA, {s3[1:0], val}, b64d_pkg::STAT_OK);
          end
        end
      endcase
      group_pos = group_pos + 2'd1;
      if (eos) begin
        // length error wins over a bad character
        if (group_pos != 2'd0) st = b64d_pkg::STAT_LENGTH;
        else if (bad_seen) st = b64d_pkg::STAT_INVALID;
        else st = b64d_pkg::STAT_OK;
        push(b64d_pkg::KIND_STATUS, 8'd0, st);
        clear_group();
      end
      if (awaited.size() > first_new) awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic kind, logic [7:0] data, logic [1:0] st, logic last);
      decoded_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind=%0d data=%h status=%0d last=%0d",
                   $realtime, kind, data, st, last);
        return;
      end
      e = awaited.pop_front();
      if (e.kind == b64d_pkg::KIND_STATUS) n_status[e.status]++;
      else n_bytes++;
      if (e.kind !== kind || e.data !== data || e.status !== b64d_pkg::status_t'(st) ||
          e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp kind=%0d data=%h status=%0d last=%0d, ",
                    "got kind=%0d data=%h status=%0d last=%0d"},
                   $realtime, e.kind, e.data, e.status, e.last, kind, data, st, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] character
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] data_byte, [9:8] status
  logic        m_tuser;   // kind
  logic        m_tlast;

  b64_decode_tracker sb = new();
  logic [7:0] text[$];
  bit         tx_idle;
  bit         rx_idle;
  bit         hold_request;
  int         random_chars;

  base64_stream_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // one transaction per side per edge at most
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_char(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[7:0], m_tdata[9:8], m_tlast);
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (!rst);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: watchdog expired, %0d results outstanding", $realtime, sb.awaited.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 99) < 30) begin
        m_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_char(logic [7:0] ch, logic eos);
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    if (tx_idle && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic send_text();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_string(string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text();
  endtask

  // the edge after the last transaction lets the tracker note it first
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic make_text();
    int groups;
    int flavour;
    int at;
    text.delete();
    groups = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
    repeat (groups * 4) text.push_back(sextet_to_char($urandom_range(0, 63)));
    case ($urandom_range(0, 2))
      1: text[$] = b64d_pkg::PAD_CHAR;
      2: begin
        text[$ - 1] = b64d_pkg::PAD_CHAR;
        text[$] = b64d_pkg::PAD_CHAR;
      end
      default: ;
    endcase
    flavour = $urandom_range(0, 99);
    at = $urandom_range(0, text.size() - 1);
    if (flavour >= 65 && flavour < 75) begin
      text.delete();
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
    end else if (flavour >= 75 && flavour < 83) begin
      repeat ($urandom_range(1, 3)) void'(text.pop_back());
    end else if (flavour >= 83 && flavour < 93) begin
      text[at] = 8'($urandom_range(0, 255));
    end else if (flavour >= 93) begin
      text[at] = b64d_pkg::PAD_CHAR;
    end
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;
    hold_request = 1'b0;
    random_chars = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_string("TWFu");
    send_string("+/z9");
    send_string("TQ==");
    send_string("AA=A");
    // pads in the first two places, then bytes at both ends of the range
    send_char(b64d_pkg::PAD_CHAR, 1'b0);
    send_char(b64d_pkg::PAD_CHAR, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_string("TW");
    send_string("!");
    drain();

    // receiver holds off while the sender keeps pushing
    tx_idle = 1'b0;
    hold_request = 1'b1;
    repeat (6) begin
      make_text();
      send_text();
    end
    drain();

    while (random_chars < RANDOM_CHARS) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      make_text();
      send_text();
      random_chars += text.size();
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d characters in %0d strings,", sb.n_chars,
             sb.n_status[0] + sb.n_status[1] + sb.n_status[2]);
    $display("  with gaps, stalls and a long back-pressure hold");
    $display("Checked %0d data bytes and status ok/length/invalid %0d/%0d/%0d, %0d mismatches",
             sb.n_bytes, sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder_unit.sv
verif/testbench.sv
